@@ rtl/core/priority_packet_request_buffer_assert.svh @@
// Assertion macros for the request buffer. Simulation gets the checks.
// Synthesis gets empty bodies.
`ifndef PRIORITY_PACKET_REQUEST_BUFFER_ASSERT_SVH
`define PRIORITY_PACKET_REQUEST_BUFFER_ASSERT_SVH
`ifndef SYNTHESIS
`define PPR_ASSERT_ALWAYS(name, clk, rstn, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (cond)) else $error(msg);
`define PPR_ASSERT_IMPLY(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);
`define PPR_ASSERT_NEXT(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PPR_ASSERT_ALWAYS(name, clk, rstn, cond, msg)
`define PPR_ASSERT_IMPLY(name, clk, rstn, ante, cons, msg)
`define PPR_ASSERT_NEXT(name, clk, rstn, ante, cons, msg)
`endif
`endif

@@ rtl/core/ppr_pkg.sv @@
`timescale 1ns / 1ps
package ppr_pkg;

    localparam int NUM_SOURCES_DEF  = 8;
    localparam int MAX_CAPACITY_DEF = 16;

    localparam int SRC_FIELD_W = 3;
    localparam int STAMP_W     = 32;
    localparam int CAP_W       = 5;
    localparam int OCC_W       = 5;
    localparam int APB_AW      = 3;
    localparam int APB_DW      = 32;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    localparam logic ACT_PUT  = 1'b0;
    localparam logic ACT_TAKE = 1'b1;

    // Register index taken from paddr[2].
    localparam logic REG_CAPACITY = 1'b0;

endpackage

@@ rtl/core/priority_packet_request_buffer.sv @@
// Sequence: a put that evicts nothing, and every item that changes nothing, loads its
// result item into the output register from state FIRST; an evicting put and a take
// read the descriptor in FIRST and the stamp in SECOND, and load the result from SECOND.
// Items are handled one at a time: no new item is taken until the last one's result is
// loaded, and loading waits while the output register holds an unaccepted result.
// Reset: aresetn is synchronous and active low; all queues empty, capacity 16.
`timescale 1ns / 1ps
module priority_packet_request_buffer #(
    parameter int NUM_SOURCES  = ppr_pkg::NUM_SOURCES_DEF,
    parameter int MAX_CAPACITY = ppr_pkg::MAX_CAPACITY_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // APB-style configuration port.
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [ppr_pkg::APB_AW-1:0]      paddr,
    input  logic [ppr_pkg::APB_DW-1:0]      pwdata,
    output logic [ppr_pkg::APB_DW-1:0]      prdata,
    output logic                            pready,
    // Input item channel.
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_action,
    input  logic [ppr_pkg::SRC_FIELD_W-1:0] s_source_index,
    input  logic [ppr_pkg::STAMP_W-1:0]     s_request_stamp,
    // Result item channel.
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic                            m_out_valid,
    output logic [ppr_pkg::SRC_FIELD_W-1:0] m_out_source,
    output logic [ppr_pkg::STAMP_W-1:0]     m_out_stamp,
    output logic [ppr_pkg::OCC_W-1:0]       m_occupancy
);

`include "priority_packet_request_buffer_assert.svh"

    // Derived sizes. Stamps for source q live in rows q*MAX_CAPACITY and up.
    localparam int SRC_W       = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;
    localparam int HEAD_W      = (MAX_CAPACITY > 1) ? $clog2(MAX_CAPACITY) : 1;
    localparam int CNT_W       = $clog2(MAX_CAPACITY + 1);
    localparam int SUM_W       = CNT_W + 1;
    localparam int STAMP_DEPTH = NUM_SOURCES * MAX_CAPACITY;
    localparam int STAMP_AW    = $clog2(STAMP_DEPTH);

    // Sequencer states. FIRST consumes the descriptor read; SECOND consumes
    // the stamp read (and the pushed queue's descriptor on an evicting put).
    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_FIRST  = 2'd1;
    localparam logic [1:0] ST_SECOND = 2'd2;

    logic [1:0]                      state_reg, state_next;
    logic                            is_put_reg, is_put_next;
    logic                            nop_reg, nop_next;
    logic                            evict_reg, evict_next;
    logic [SRC_W-1:0]                src_reg, src_next;
    logic [SRC_W-1:0]                q_reg, q_next;
    logic [ppr_pkg::STAMP_W-1:0]     stamp_reg, stamp_next;
    logic [HEAD_W-1:0]               fwd_head_reg, fwd_head_next;
    logic [CNT_W-1:0]                fwd_count_reg, fwd_count_next;
    logic [CNT_W-1:0]                total_reg, total_next;
    logic [SRC_W-1:0]                cur_pkt_reg, cur_pkt_next;
    logic [NUM_SOURCES-1:0]          mask_reg, mask_next;
    logic [ppr_pkg::CAP_W-1:0]       cap_reg, cap_next;

    logic                            m_valid_reg, m_valid_next;
    logic                            m_out_valid_reg, m_out_valid_next;
    logic [ppr_pkg::SRC_FIELD_W-1:0] m_out_source_reg, m_out_source_next;
    logic [ppr_pkg::STAMP_W-1:0]     m_out_stamp_reg, m_out_stamp_next;
    logic [ppr_pkg::OCC_W-1:0]       m_occupancy_reg, m_occupancy_next;

    // Memory ports.
    logic                            qt_rd_en, qt_wr_en;
    logic [SRC_W-1:0]                qt_rd_addr, qt_wr_addr;
    logic [HEAD_W-1:0]               qt_rd_head, qt_wr_head;
    logic [CNT_W-1:0]                qt_rd_count, qt_wr_count;
    logic                            st_rd_en, st_wr_en;
    logic [STAMP_AW-1:0]             st_rd_addr, st_wr_addr;
    logic [ppr_pkg::STAMP_W-1:0]     st_rd_data;

    // Helpers.
    logic                            accept, out_free, cfg_write;
    logic [31:0]                     src_wide, cap_wide, cap_eff, q_wide, occ_wide;
    logic                            src_ok, need_evict;
    logic [SRC_W-1:0]                src_idx, hi_idx, lo_idx, take_cur;
    logic [HEAD_W-1:0]               pop_head, push_head;
    logic [CNT_W-1:0]                pop_count, push_count, occ_val;
    logic [SUM_W-1:0]                tail_sum, tail_wrap;
    logic [HEAD_W-1:0]               tail_slot;
    logic [STAMP_AW-1:0]             pop_addr, push_addr;
    logic                            load_out, load_valid;
    logic [ppr_pkg::STAMP_W-1:0]     load_stamp;

    ppr_queue_table #(
        .NUM_SOURCES (NUM_SOURCES),
        .SRC_W       (SRC_W),
        .HEAD_W      (HEAD_W),
        .CNT_W       (CNT_W)
    ) u_queue_table (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rd_en    (qt_rd_en),
        .rd_addr  (qt_rd_addr),
        .rd_head  (qt_rd_head),
        .rd_count (qt_rd_count),
        .wr_en    (qt_wr_en),
        .wr_addr  (qt_wr_addr),
        .wr_head  (qt_wr_head),
        .wr_count (qt_wr_count)
    );

    ppr_stamp_ram #(
        .DEPTH (STAMP_DEPTH),
        .AW    (STAMP_AW)
    ) u_stamp_ram (
        .aclk    (aclk),
        .rd_en   (st_rd_en),
        .rd_addr (st_rd_addr),
        .rd_data (st_rd_data),
        .wr_en   (st_wr_en),
        .wr_addr (st_wr_addr),
        .wr_data (stamp_reg)
    );

    // Configuration port. The single register sits at word 0; a write to
    // word 1 is ignored and reads there return zero.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign prdata    = (paddr[2] == ppr_pkg::REG_CAPACITY)
                     ? ppr_pkg::APB_DW'(cap_reg) : '0;

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    // Source check and the capacity clamp (zero acts as one, large values
    // are limited to the storage size).
    assign src_wide = 32'(s_source_index);
    assign src_ok   = src_wide < 32'(NUM_SOURCES);
    assign src_idx  = src_wide[SRC_W-1:0];
    assign cap_wide = 32'(cap_reg);
    assign cap_eff  = (cap_wide == 32'd0) ? 32'd1
                    : (cap_wide > 32'(MAX_CAPACITY)) ? 32'(MAX_CAPACITY) : cap_wide;
    assign need_evict = (32'(total_reg) >= cap_eff) && (total_reg != '0);

    // Eviction takes from the highest-numbered non-empty queue; a take that
    // finds its current queue empty moves to the lowest-numbered one.
    always_comb begin
        hi_idx = '0;
        for (int i = 0; i < NUM_SOURCES; i++) begin
            if (mask_reg[i]) begin
                hi_idx = SRC_W'(i);
            end
        end
        lo_idx = '0;
        for (int i = NUM_SOURCES - 1; i >= 0; i--) begin
            if (mask_reg[i]) begin
                lo_idx = SRC_W'(i);
            end
        end
    end

    assign take_cur = mask_reg[cur_pkt_reg] ? cur_pkt_reg : lo_idx;

    // Pop works on the descriptor just read. Push works on the pushed
    // queue's descriptor, forwarded from the pop when an evicting put hits
    // its own queue, since the read overlapped the write-back of that entry.
    assign pop_head  = (qt_rd_head == HEAD_W'(MAX_CAPACITY - 1)) ? '0
                     : qt_rd_head + HEAD_W'(1);
    assign pop_count = qt_rd_count - CNT_W'(1);
    assign pop_addr  = STAMP_AW'(q_reg) * STAMP_AW'(MAX_CAPACITY) + STAMP_AW'(qt_rd_head);

    always_comb begin
        if (evict_reg && (state_reg == ST_SECOND) && (src_reg == q_reg)) begin
            push_head  = fwd_head_reg;
            push_count = fwd_count_reg;
        end else begin
            push_head  = qt_rd_head;
            push_count = qt_rd_count;
        end
    end

    // The tail never reaches twice the row size, so one subtract wraps it.
    assign tail_sum  = SUM_W'(push_head) + SUM_W'(push_count);
    assign tail_wrap = (tail_sum >= SUM_W'(MAX_CAPACITY)) ? tail_sum - SUM_W'(MAX_CAPACITY)
                     : tail_sum;
    assign tail_slot = tail_wrap[HEAD_W-1:0];
    assign push_addr = STAMP_AW'(src_reg) * STAMP_AW'(MAX_CAPACITY) + STAMP_AW'(tail_slot);

    assign q_wide = 32'(q_reg);

    always_comb begin
        state_next     = state_reg;
        is_put_next    = is_put_reg;
        nop_next       = nop_reg;
        evict_next     = evict_reg;
        src_next       = src_reg;
        q_next         = q_reg;
        stamp_next     = stamp_reg;
        fwd_head_next  = fwd_head_reg;
        fwd_count_next = fwd_count_reg;
        total_next     = total_reg;
        cur_pkt_next   = cur_pkt_reg;
        mask_next      = mask_reg;
        cap_next       = cfg_write && (paddr[2] == ppr_pkg::REG_CAPACITY)
                       ? pwdata[ppr_pkg::CAP_W-1:0] : cap_reg;

        qt_rd_en    = 1'b0;
        qt_rd_addr  = src_idx;
        qt_wr_en    = 1'b0;
        qt_wr_addr  = src_reg;
        qt_wr_head  = push_head;
        qt_wr_count = push_count + CNT_W'(1);
        st_rd_en    = 1'b0;
        st_rd_addr  = pop_addr;
        st_wr_en    = 1'b0;
        st_wr_addr  = push_addr;

        load_out   = 1'b0;
        load_valid = 1'b0;
        load_stamp = '0;
        occ_val    = total_reg;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next  = ST_FIRST;
                    is_put_next = (s_action == ppr_pkg::ACT_PUT);
                    src_next    = src_idx;
                    stamp_next  = s_request_stamp;
                    evict_next  = 1'b0;
                    nop_next    = 1'b0;
                    if (s_action == ppr_pkg::ACT_PUT) begin
                        if (!src_ok) begin
                            nop_next = 1'b1;
                        end else if (need_evict) begin
                            evict_next = 1'b1;
                            q_next     = hi_idx;
                            qt_rd_en   = 1'b1;
                            qt_rd_addr = hi_idx;
                        end else begin
                            qt_rd_en   = 1'b1;
                            qt_rd_addr = src_idx;
                        end
                    end else begin
                        if (total_reg == '0) begin
                            nop_next = 1'b1;
                        end else begin
                            q_next       = take_cur;
                            cur_pkt_next = take_cur;
                            qt_rd_en     = 1'b1;
                            qt_rd_addr   = take_cur;
                        end
                    end
                end
            end
            ST_FIRST: begin
                if (nop_reg) begin
                    if (out_free) begin
                        load_out   = 1'b1;
                        state_next = ST_IDLE;
                    end
                end else if (evict_reg || !is_put_reg) begin
                    // Pop the front of queue q_reg.
                    st_rd_en    = 1'b1;
                    qt_wr_en    = 1'b1;
                    qt_wr_addr  = q_reg;
                    qt_wr_head  = pop_head;
                    qt_wr_count = pop_count;
                    total_next  = total_reg - CNT_W'(1);
                    if (qt_rd_count == CNT_W'(1)) begin
                        mask_next[q_reg] = 1'b0;
                    end
                    fwd_head_next  = pop_head;
                    fwd_count_next = pop_count;
                    if (evict_reg) begin
                        qt_rd_en   = 1'b1;
                        qt_rd_addr = src_reg;
                    end
                    state_next = ST_SECOND;
                end else if (out_free) begin
                    // Plain put: append to the source's queue.
                    st_wr_en          = 1'b1;
                    qt_wr_en          = 1'b1;
                    total_next        = total_reg + CNT_W'(1);
                    mask_next[src_reg] = 1'b1;
                    load_out          = 1'b1;
                    occ_val           = total_reg + CNT_W'(1);
                    state_next        = ST_IDLE;
                end
            end
            ST_SECOND: begin
                if (out_free) begin
                    load_out   = 1'b1;
                    load_valid = 1'b1;
                    load_stamp = st_rd_data;
                    state_next = ST_IDLE;
                    if (is_put_reg) begin
                        st_wr_en           = 1'b1;
                        qt_wr_en           = 1'b1;
                        total_next         = total_reg + CNT_W'(1);
                        mask_next[src_reg] = 1'b1;
                        occ_val            = total_reg + CNT_W'(1);
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign occ_wide = 32'(occ_val);

    // Output register; a result item waits here while the next item is taken in.
    always_comb begin
        m_valid_next      = m_valid_reg && !m_ready;
        m_out_valid_next  = m_out_valid_reg;
        m_out_source_next = m_out_source_reg;
        m_out_stamp_next  = m_out_stamp_reg;
        m_occupancy_next  = m_occupancy_reg;
        if (load_out) begin
            m_valid_next      = 1'b1;
            m_out_valid_next  = load_valid;
            m_out_source_next = load_valid ? q_wide[ppr_pkg::SRC_FIELD_W-1:0] : '0;
            m_out_stamp_next  = load_stamp;
            m_occupancy_next  = occ_wide[ppr_pkg::OCC_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            is_put_reg  <= 1'b0;
            nop_reg     <= 1'b0;
            evict_reg   <= 1'b0;
            total_reg   <= '0;
            cur_pkt_reg <= '0;
            mask_reg    <= '0;
            cap_reg     <= ppr_pkg::CAP_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            is_put_reg  <= is_put_next;
            nop_reg     <= nop_next;
            evict_reg   <= evict_next;
            total_reg   <= total_next;
            cur_pkt_reg <= cur_pkt_next;
            mask_reg    <= mask_next;
            cap_reg     <= cap_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        src_reg          <= src_next;
        q_reg            <= q_next;
        stamp_reg        <= stamp_next;
        fwd_head_reg     <= fwd_head_next;
        fwd_count_reg    <= fwd_count_next;
        m_out_valid_reg  <= m_out_valid_next;
        m_out_source_reg <= m_out_source_next;
        m_out_stamp_reg  <= m_out_stamp_next;
        m_occupancy_reg  <= m_occupancy_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_out_valid  = m_out_valid_reg;
    assign m_out_source = m_out_source_reg;
    assign m_out_stamp  = m_out_stamp_reg;
    assign m_occupancy  = m_occupancy_reg;

    // The occupancy never exceeds the storage size.
    `PPR_ASSERT_ALWAYS(a_total_bound, aclk, aresetn,
        32'(total_reg) <= 32'(MAX_CAPACITY), "occupancy above storage size")
    // The non-empty mask and the total count agree on an empty buffer.
    `PPR_ASSERT_ALWAYS(a_mask_total, aclk, aresetn,
        (total_reg == '0) == (mask_reg == '0), "mask and total disagree")
    // A pop always finds a non-empty descriptor in the queue table.
    `PPR_ASSERT_IMPLY(a_pop_nonempty, aclk, aresetn,
        (state_reg == ST_FIRST) && !nop_reg && (evict_reg || !is_put_reg),
        qt_rd_count != '0, "pop from empty queue")
    // After an eviction the push always finds room in the storage.
    `PPR_ASSERT_IMPLY(a_evict_room, aclk, aresetn, (state_reg == ST_SECOND) && is_put_reg,
        32'(total_reg) < 32'(MAX_CAPACITY), "no room after eviction")
    // An accepted item always leaves the idle state on the next edge.
    `PPR_ASSERT_NEXT(a_accept_busy, aclk, aresetn, accept, state_reg == ST_FIRST,
        "accepted item not started")

endmodule

@@ rtl/core/ppr_stamp_ram.sv @@
`timescale 1ns / 1ps
// Stamp storage: one slot row per source, one read and one write port.
module ppr_stamp_ram #(
    parameter int DEPTH = ppr_pkg::NUM_SOURCES_DEF * ppr_pkg::MAX_CAPACITY_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                        aclk,
    input  logic                        rd_en,
    input  logic [AW-1:0]               rd_addr,
    output logic [ppr_pkg::STAMP_W-1:0] rd_data,
    input  logic                        wr_en,
    input  logic [AW-1:0]               wr_addr,
    input  logic [ppr_pkg::STAMP_W-1:0] wr_data
);

    logic [ppr_pkg::STAMP_W-1:0] mem [DEPTH];
    logic [ppr_pkg::STAMP_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/core/ppr_queue_table.sv @@
`timescale 1ns / 1ps
// Per-source queue descriptors (head slot and count). An entry that was
// never written since reset reads as an empty queue with head zero.
module ppr_queue_table #(
    parameter int NUM_SOURCES = ppr_pkg::NUM_SOURCES_DEF,
    parameter int SRC_W       = 3,
    parameter int HEAD_W      = 4,
    parameter int CNT_W       = 5
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              rd_en,
    input  logic [SRC_W-1:0]  rd_addr,
    output logic [HEAD_W-1:0] rd_head,
    output logic [CNT_W-1:0]  rd_count,
    input  logic              wr_en,
    input  logic [SRC_W-1:0]  wr_addr,
    input  logic [HEAD_W-1:0] wr_head,
    input  logic [CNT_W-1:0]  wr_count
);

    logic [HEAD_W+CNT_W-1:0] mem [NUM_SOURCES];
    logic [NUM_SOURCES-1:0]  written_reg;
    logic [HEAD_W+CNT_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= {wr_head, wr_count};
        end
        if (rd_en) begin
            rd_data_reg <= written_reg[rd_addr] ? mem[rd_addr] : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            written_reg <= '0;
        end else if (wr_en) begin
            written_reg[wr_addr] <= 1'b1;
        end
    end

    assign rd_head  = rd_data_reg[HEAD_W+CNT_W-1:CNT_W];
    assign rd_count = rd_data_reg[CNT_W-1:0];

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 1ps
module tb;
    import ppr_pkg::*;

    // The run ends here even if the block stops answering.
    localparam int CYCLE_LIMIT = 400000;

    // Cycles to let pass after the last result before a register write or the end.
    localparam int SETTLE_CYCLES = 4;

    // Length of each deliberate output hold-off.
    localparam int LONG_HOLD_CYCLES = 300;

    // Stall patterns of the result side.
    localparam int RX_FREE   = 0;
    localparam int RX_HALF   = 1;
    localparam int RX_SPARSE = 2;

    localparam int RANDOM_PHASES    = 10;
    localparam int ITEMS_PER_PHASE  = 170;

    // One result item as the block reports it.
    typedef struct packed {
        logic                   out_valid;
        logic [SRC_FIELD_W-1:0] out_source;
        logic [STAMP_W-1:0]     out_stamp;
        logic [OCC_W-1:0]       occupancy;
    } request_result_t;

    // Tracks the buffer contents the block should hold and the result items that
    // are still owed. Each accepted input item is applied here in order of
    // acceptance, and each result item is compared with the oldest one owed.
    class buffer_tracker;
        logic [STAMP_W-1:0] stamp_mem [NUM_SOURCES_DEF][MAX_CAPACITY_DEF];
        int unsigned        q_head  [NUM_SOURCES_DEF];
        int unsigned        q_count [NUM_SOURCES_DEF];
        int unsigned        total;
        int unsigned        cur_packet;
        logic [CAP_W-1:0]   capacity_reg;
        request_result_t    owed_results [$];
        int                 errors;

        function new();
            foreach (q_head[i]) begin
                q_head[i]  = 0;
                q_count[i] = 0;
            end
            total        = 0;
            cur_packet   = 0;
            capacity_reg = CAP_RESET;
            errors       = 0;
        endfunction

        function void set_capacity(logic [CAP_W-1:0] value);
            capacity_reg = value;
        endfunction

        // Out-of-range capacity values saturate to the legal range.
        function int unsigned usable_capacity();
            if (capacity_reg == 0)
                return 1;
            if (capacity_reg > MAX_CAPACITY_DEF)
                return MAX_CAPACITY_DEF;
            return capacity_reg;
        endfunction

        function logic [STAMP_W-1:0] take_front(int unsigned q);
            logic [STAMP_W-1:0] v;
            v         = stamp_mem[q][q_head[q]];
            q_head[q] = (q_head[q] + 1) % MAX_CAPACITY_DEF;
            q_count[q]--;
            total--;
            return v;
        endfunction

        function void note_request(logic act, logic [SRC_FIELD_W-1:0] src,
                                   logic [STAMP_W-1:0] stamp);
            request_result_t r;
            int unsigned     pos;
            r = '0;
            if (act == ACT_PUT) begin
                // A full buffer drops the oldest request of the least urgent source.
                if (total >= usable_capacity() && total > 0) begin
                    for (int q = NUM_SOURCES_DEF - 1; q >= 0; q--) begin
                        if (q_count[q] != 0) begin
                            r.out_valid  = 1'b1;
                            r.out_source = q[SRC_FIELD_W-1:0];
                            r.out_stamp  = take_front(q);
                            break;
                        end
                    end
                end
                pos = (q_head[src] + q_count[src]) % MAX_CAPACITY_DEF;
                stamp_mem[src][pos] = stamp;
                q_count[src]++;
                total++;
            end else if (total != 0) begin
                // The current packet sticks until its queue runs dry.
                if (q_count[cur_packet] == 0) begin
                    for (int q = 0; q < NUM_SOURCES_DEF; q++) begin
                        if (q_count[q] != 0) begin
                            cur_packet = q;
                            break;
                        end
                    end
                end
                r.out_valid  = 1'b1;
                r.out_source = cur_packet[SRC_FIELD_W-1:0];
                r.out_stamp  = take_front(cur_packet);
            end
            r.occupancy = total[OCC_W-1:0];
            owed_results.insert(owed_results.size(), r);
        endfunction

        function void check_result(request_result_t got);
            request_result_t exp;
            if (owed_results.size() == 0) begin
                $error("result item arrived with no request waiting");
                errors++;
                return;
            end
            exp = owed_results[0];
            owed_results.delete(0);
            if (got.out_valid !== exp.out_valid) begin
                $error("out_valid: expected %0d, got %0d", exp.out_valid, got.out_valid);
                errors++;
            end
            if (got.out_source !== exp.out_source) begin
                $error("out_source: expected %0d, got %0d", exp.out_source, got.out_source);
                errors++;
            end
            if (got.out_stamp !== exp.out_stamp) begin
                $error("out_stamp: expected %h, got %h", exp.out_stamp, got.out_stamp);
                errors++;
            end
            if (got.occupancy !== exp.occupancy) begin
                $error("occupancy: expected %0d, got %0d", exp.occupancy, got.occupancy);
                errors++;
            end
        endfunction

        function int pending();
            return owed_results.size();
        endfunction
    endclass

    // Every input of the block starts at a known value.
    logic                   aclk            = 1'b0;
    logic                   aresetn         = 1'b0;
    logic                   psel            = 1'b0;
    logic                   penable         = 1'b0;
    logic                   pwrite          = 1'b0;
    logic [APB_AW-1:0]      paddr           = '0;
    logic [APB_DW-1:0]      pwdata          = '0;
    logic [APB_DW-1:0]      prdata;
    logic                   pready;
    logic                   s_valid         = 1'b0;
    logic                   s_ready;
    logic                   s_action        = ACT_PUT;
    logic [SRC_FIELD_W-1:0] s_source_index  = '0;
    logic [STAMP_W-1:0]     s_request_stamp = '0;
    logic                   m_valid;
    logic                   m_ready         = 1'b0;
    logic                   m_out_valid;
    logic [SRC_FIELD_W-1:0] m_out_source;
    logic [STAMP_W-1:0]     m_out_stamp;
    logic [OCC_W-1:0]       m_occupancy;

    buffer_tracker tracker = new();

    int cycle_count   = 0;
    int hold_requests = 0;

    priority_packet_request_buffer i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_action        (s_action),
        .s_source_index  (s_source_index),
        .s_request_stamp (s_request_stamp),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_out_valid     (m_out_valid),
        .m_out_source    (m_out_source),
        .m_out_stamp     (m_out_stamp),
        .m_occupancy     (m_occupancy)
    );

    always #5 aclk = ~aclk;

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb failed");
            $finish;
        end
    end

    // Both channels are sampled at the clock edge, where every signal still holds
    // the value it had before the edge. A result item can never belong to an item
    // accepted at the same edge, so checking before noting is safe.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            tracker.check_result({m_out_valid, m_out_source, m_out_stamp, m_occupancy});
        if (aresetn && s_valid && s_ready)
            tracker.note_request(s_action, s_source_index, s_request_stamp);
    end

    // The result side switches between stall patterns on its own schedule:
    // always ready, ready about half the time, and ready one cycle in four.
    // When the stimulus asks for it, it also holds off for a long stretch so that
    // the block backs up and has to stall its input.
    initial begin
        int rx_mode;
        int mode_left;
        int hold_left;
        int holds_served;
        rx_mode      = RX_FREE;
        mode_left    = 0;
        hold_left    = 0;
        holds_served = 0;
        forever begin
            @(posedge aclk);
            if (holds_served != hold_requests) begin
                holds_served = hold_requests;
                hold_left    = LONG_HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    rx_mode   = $urandom_range(RX_SPARSE, RX_FREE);
                    mode_left = $urandom_range(96, 16);
                end
                mode_left--;
                case (rx_mode)
                    RX_FREE: begin
                        m_ready <= 1'b1;
                    end
                    RX_HALF: begin
                        m_ready <= ($urandom_range(1, 0) == 1);
                    end
                    default: begin
                        m_ready <= ($urandom_range(3, 0) == 0);
                    end
                endcase
            end
        end
    end

    // Offers one item and returns at the edge where it is taken. Valid is left
    // high so that the next item can follow without a gap; the caller lowers it.
    task automatic send_item(input logic act, input logic [SRC_FIELD_W-1:0] src,
                             input logic [STAMP_W-1:0] stamp);
        s_valid         <= 1'b1;
        s_action        <= act;
        s_source_index  <= src;
        s_request_stamp <= stamp;
        do
            @(posedge aclk);
        while (!s_ready);
    endtask

    task automatic send_put(input logic [SRC_FIELD_W-1:0] src,
                            input logic [STAMP_W-1:0] stamp);
        send_item(ACT_PUT, src, stamp);
    endtask

    // The source and stamp fields are don't-care on a take, so they carry noise.
    task automatic send_take();
        send_item(ACT_TAKE, SRC_FIELD_W'($urandom_range(NUM_SOURCES_DEF - 1, 0)), $urandom);
    endtask

    // Lowers valid and waits until every owed result item has come back, then
    // lets the block settle into idle, so the capacity can safely change.
    // The first edge lets the item taken at the previous edge be noted.
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (tracker.pending() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic read_capacity(input logic [CAP_W-1:0] want);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {REG_CAPACITY, 2'b00};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        if (prdata !== APB_DW'(want)) begin
            $error("capacity: expected %0d, got %0d", want, prdata);
            tracker.errors++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Writes the capacity register (block idle only) and reads it back.
    task automatic write_capacity(input logic [CAP_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_CAPACITY, 2'b00};
        pwdata  <= APB_DW'(value);
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        tracker.set_capacity(value);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        read_capacity(value);
    endtask

    initial begin
        int               items_left;
        int               burst;
        int               gap;
        int               put_pct;
        bit               no_gaps;
        logic [CAP_W-1:0] cap_value;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        read_capacity(CAP_RESET);

        // Directed part. With the reset capacity: a take from an empty buffer,
        // stamps at both extremes, and takes that walk the sources from the most
        // urgent one up, ending with another take from an empty buffer.
        send_take();
        send_put(3'd0, 32'h0000_0000);
        send_put(3'd7, 32'hFFFF_FFFF);
        send_put(3'd3, 32'h1234_5678);
        send_put(3'd0, 32'hA5A5_A5A5);
        send_take();
        send_take();
        send_take();
        send_take();
        send_take();
        drain();

        // A capacity of zero acts as one, so every put after the first evicts.
        write_capacity(5'd0);
        send_put(3'd2, 32'hAAAA_AAAA);
        send_put(3'd6, 32'h5555_5555);
        send_put(3'd1, 32'hDEAD_BEEF);
        send_take();
        drain();

        // Fill three entries, then lower the capacity below the occupancy: puts
        // still evict one request each, so the occupancy holds, and only takes
        // bring it down.
        write_capacity(5'd3);
        send_put(3'd4, 32'h0F0F_0F0F);
        send_put(3'd5, 32'hF0F0_F0F0);
        send_put(3'd4, 32'h8000_0001);
        drain();
        write_capacity(5'd1);
        send_put(3'd1, 32'h7FFF_FFFE);
        send_put(3'd2, 32'h0000_0001);
        send_take();
        send_take();
        send_take();
        drain();

        // Random part. Each phase runs at one capacity; the first few phases hit
        // the extremes, including a value above the range that saturates. The
        // put share varies so that some phases keep the buffer full and evicting,
        // others drain it and make the current packet move between sources.
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0:       cap_value = 5'd31;
                1:       cap_value = 5'd16;
                2:       cap_value = 5'd1;
                3:       cap_value = 5'd17;
                4:       cap_value = 5'd0;
                default: cap_value = CAP_W'($urandom_range(31, 0));
            endcase
            write_capacity(cap_value);

            put_pct = $urandom_range(85, 35);
            no_gaps = (phase % 3 == 0);

            // Twice in the run the result side stops for a long stretch while the
            // sender keeps offering mostly puts, so the block fills and stalls.
            if (phase == 1 || phase == 6) begin
                put_pct = 80;
                hold_requests = hold_requests + 1;
            end

            items_left = ITEMS_PER_PHASE;
            while (items_left > 0) begin
                burst = $urandom_range(24, 1);
                if (burst > items_left)
                    burst = items_left;
                repeat (burst) begin
                    if ($urandom_range(99, 0) < put_pct)
                        send_put(SRC_FIELD_W'($urandom_range(NUM_SOURCES_DEF - 1, 0)),
                                 $urandom);
                    else
                        send_take();
                end
                items_left -= burst;
                gap = no_gaps ? 0 : $urandom_range(8, 0);
                if (gap > 0 && items_left > 0) begin
                    s_valid <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
            end
            drain();
        end

        if (tracker.errors == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/ppr_pkg.sv
rtl/core/ppr_stamp_ram.sv
rtl/core/ppr_queue_table.sv
rtl/core/priority_packet_request_buffer.sv
sim/tb.sv
